// File: rtl/core/ird_pkg.sv
// Package for the interpolation residual decoder: segment and result types, divide helpers.
`default_nettype none

package ird_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 18;

  // ceil(2^17 / 3): exact floor(a/3) for any a below 2^17
  localparam logic [15:0] RECIP3 = 16'd43691;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

  // One segment waiting for interpolation
  typedef struct packed {
    sample_t prev;
    sample_t anchor;
    sample_t r1;
    sample_t r2;
    sample_t r3;
    logic    last;
  } seg_t;

  // One rebuilt group of four samples
  typedef struct packed {
    sample_t s0;
    sample_t s1;
    sample_t s2;
    sample_t s3;
    logic    final_grp;
  } grp_t;

  function automatic sum_t sext(input sample_t v);
    return {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  // Signed divide by 4, truncated toward zero
  function automatic sum_t div4_trunc(input sum_t x);
    sum_t a;
    a = x + (x[SUM_W-1] ? sum_t'(3) : sum_t'(0));
    return {{2{a[SUM_W-1]}}, a[SUM_W-1:2]};
  endfunction

  // Signed divide by 2, truncated toward zero
  function automatic sum_t div2_trunc(input sum_t x);
    sum_t a;
    a = x + {{(SUM_W-1){1'b0}}, x[SUM_W-1]};
    return {a[SUM_W-1], a[SUM_W-1:1]};
  endfunction

  // Signed divide by 3, truncated toward zero; |x| stays below 2^17
  function automatic sum_t div3_trunc(input sum_t x);
    sum_t        mag;
    logic [32:0] prod;
    sum_t        q;
    mag  = x[SUM_W-1] ? (~x + sum_t'(1)) : x;
    prod = mag[16:0] * RECIP3;
    q    = {2'b00, prod[32:17]};
    return x[SUM_W-1] ? (~q + sum_t'(1)) : q;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/interp_residual_decoder_unit.sv
// Path: an accepted segment beat is held in the segment register, then in the output register.
// Throughput: one input beat per cycle while the output is not stalled; a block opener yields no output beat.
// The rate is set by the single pass through the interpolation datapath.
// Reset clears the prior anchor to zero, closes any open block, empties both stages.
// Input stall rises only while both the segment and output registers are held.
`default_nettype none

module interp_residual_decoder_unit
  import ird_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire sample_t anchor_value,
  input  wire sample_t resid_one,
  input  wire sample_t resid_two,
  input  wire sample_t resid_three,
  input  wire logic    block_start,
  input  wire logic    block_end,
  output logic         out_valid,
  input  wire logic    out_stall,
  output sample_t      sample_zero,
  output sample_t      sample_one,
  output sample_t      sample_two,
  output sample_t      sample_three,
  output logic         final_group
);

  logic fwd_ready;
  logic seg_valid;
  seg_t seg;
  grp_t grp;
  grp_t res;
  logic load;

  assign fwd_ready = !out_valid || !out_stall;
  assign load      = seg_valid && fwd_ready;

  ird_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .anchor_value (anchor_value),
    .resid_one    (resid_one),
    .resid_two    (resid_two),
    .resid_three  (resid_three),
    .block_start  (block_start),
    .block_end    (block_end),
    .fwd_ready    (fwd_ready),
    .seg_valid    (seg_valid),
    .seg          (seg)
  );

  ird_interp u_interp (
    .seg (seg),
    .grp (grp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= grp;
    end
  end

  assign sample_zero  = res.s0;
  assign sample_one   = res.s1;
  assign sample_two   = res.s2;
  assign sample_three = res.s3;
  assign final_group  = res.final_grp;

  // Input held back only when both stages are full and the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (seg_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // A waiting segment follows a taken output beat with no bubble
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && seg_valid) |=> out_valid)
    else $error("bubble between output beats");

  // Last segment passes the new anchor through as the fourth sample
  a_final_anchor: assert property (@(posedge clk) disable iff (rst)
    (load && seg.last) |=> (final_group && sample_three == $past(seg.anchor)))
    else $error("final group lost the closing anchor");

  // First sample is always the prior anchor of the segment
  a_prev_pass: assert property (@(posedge clk) disable iff (rst)
    load |=> (sample_zero == $past(seg.prev)))
    else $error("sample zero differs from prior anchor");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

// File: rtl/core/ird_front.sv
// Input stage: keeps the prior anchor, drops block openers, registers segments.
`default_nettype none

module ird_front
  import ird_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire sample_t anchor_value,
  input  wire sample_t resid_one,
  input  wire sample_t resid_two,
  input  wire sample_t resid_three,
  input  wire logic    block_start,
  input  wire logic    block_end,
  input  wire logic    fwd_ready,
  output logic         seg_valid,
  output seg_t         seg
);

  sample_t prior_anchor;
  logic    anchor_valid;
  logic    accept;
  logic    opens;

  // Held segment blocks new beats only when it cannot move on
  assign in_stall = seg_valid && !fwd_ready;
  assign accept   = in_valid && !in_stall;
  assign opens    = block_start || !anchor_valid;

  // Anchor state
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_anchor <= '0;
      anchor_valid <= 1'b0;
    end else if (accept) begin
      prior_anchor <= anchor_value;
      anchor_valid <= opens ? 1'b1 : !block_end;
    end
  end

  // Segment register; openers never occupy it
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (accept) begin
      seg_valid <= !opens;
    end else if (fwd_ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg.prev   <= prior_anchor;
      seg.anchor <= anchor_value;
      seg.r1     <= resid_one;
      seg.r2     <= resid_two;
      seg.r3     <= resid_three;
      seg.last   <= block_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ird_interp.sv
// Interpolation datapath: quarter or third points minus residuals, 16-bit wrap.
`default_nettype none

module ird_interp
  import ird_pkg::*;
(
  input  wire seg_t seg,
  output grp_t      grp
);

  sum_t p;
  sum_t n;
  sum_t q1;
  sum_t q2;
  sum_t q3;
  sum_t t1;
  sum_t t2;

  assign p = sext(seg.prev);
  assign n = sext(seg.anchor);

  // Interpolated points
  always_comb begin
    if (seg.last) begin
      q1 = div3_trunc({p[SUM_W-2:0], 1'b0} + n);
      q2 = div3_trunc(p + {n[SUM_W-2:0], 1'b0});
    end else begin
      q1 = div4_trunc({p[SUM_W-2:0], 1'b0} + p + n);
      q2 = div2_trunc(p + n);
    end
    q3 = div4_trunc(p + {n[SUM_W-2:0], 1'b0} + n);
  end

  // Residual removal; upper bits drop for the wrap
  assign t1 = q1 - sext(seg.r1);
  assign t2 = q2 - sext(seg.r2);

  always_comb begin
    grp.s0        = seg.prev;
    grp.s1        = t1[SAMPLE_W-1:0];
    grp.s2        = t2[SAMPLE_W-1:0];
    grp.s3        = seg.last ? seg.anchor : (q3[SAMPLE_W-1:0] - seg.r3);
    grp.final_grp = seg.last;
  end

endmodule

`default_nettype wire
